[rtl/core/timed_job_queue_retry_backoff_top_defines.svh]
// ----------------------------------------------------------------------------
// timed_job_queue_retry_backoff_top_defines.svh
// Assertion macros used by the checker file of the timed job queue.
// ----------------------------------------------------------------------------
`ifndef TIMED_JOB_QUEUE_RETRY_BACKOFF_TOP_DEFINES_SVH
`define TIMED_JOB_QUEUE_RETRY_BACKOFF_TOP_DEFINES_SVH

// same-cycle implication, reset masks the check
`define TJQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define TJQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tjq_pkg.sv]
// ----------------------------------------------------------------------------
// tjq_pkg
// Types and constants of the timed job queue with retry backoff.
// ----------------------------------------------------------------------------
`default_nettype none

package tjq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int MAX_RES     = 16;
    localparam int CNT_W       = $clog2(MAX_RES);

    localparam int ID_W    = 16;
    localparam int TIME_W  = 32;
    localparam int RETRY_W = 4;
    localparam int UNIT_W  = 16;
    localparam int FUNC_W  = 2;
    localparam int KIND_W  = 3;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;

    localparam logic [UNIT_W-1:0] BACKOFF_RST = 16'd1000;

    // input operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_INSERTED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DISPATCHED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COMPLETED  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REQUEUED   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FAILED     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN    = 3'd6;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_SCHED = 2'd1,
        SLOT_RUN   = 2'd2
    } t_slot_st;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_DECIDE = 2'd2,
        ST_EMIT   = 2'd3
    } t_state;

    typedef struct packed {
        logic load;       // capture input beat
        logic scan_clr;   // restart the table walk
        logic scan_step;  // examine one slot
        logic decide;     // update table, build result
        logic out_load;   // move result to output register
        logic next_job;   // count one dispatched job
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              scan_done;
        logic              found;
        logic              res_last;
        logic              out_free;
    } t_sts;

endpackage

`default_nettype wire

[rtl/core/tjq_ctrl.sv]
// ----------------------------------------------------------------------------
// tjq_ctrl
// Sequencer: accept a beat, walk the table, act on the chosen slot, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module tjq_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_s_tvalid,
    input  wire  [1:0]     i_s_func,
    output logic           o_s_tready,
    input  tjq_pkg::t_sts  i_sts,
    output tjq_pkg::t_cmd  o_cmd
);
    import tjq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    // unused code: no result, nothing changes
                    if (i_s_func inside {FUNC_INSERT, FUNC_TICK, FUNC_REPORT}) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_sts.func == FUNC_TICK && !i_sts.found) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.decide = 1'b1;
                    n_state      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.res_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.scan_clr = 1'b1;
                        o_cmd.next_job = 1'b1;
                        n_state        = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/tjq_dp.sv]
// ----------------------------------------------------------------------------
// tjq_dp
// Job table, time counter, slot walker and result / output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tjq_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [tjq_pkg::UNIT_W-1:0]       i_cfg_wdata,
    input  wire  [tjq_pkg::FUNC_W-1:0]       i_func,
    input  wire  [tjq_pkg::ID_W-1:0]         i_job_id,
    input  wire  [tjq_pkg::TIME_W-1:0]       i_release_time,
    input  wire  [tjq_pkg::RETRY_W-1:0]      i_max_retry,
    input  wire                              i_outcome_failed,
    input  tjq_pkg::t_cmd                    i_cmd,
    output tjq_pkg::t_sts                    o_sts,
    input  wire                              i_m_tready,
    output logic                             o_m_valid,
    output logic [tjq_pkg::KIND_W-1:0]       o_m_kind,
    output logic [tjq_pkg::ID_W-1:0]         o_m_job_id,
    output logic [tjq_pkg::RETRY_W-1:0]      o_m_retry,
    output logic [tjq_pkg::TIME_W-1:0]       o_m_release,
    output logic                             o_m_last
);
    import tjq_pkg::*;

    // job table: status has reset, payload is only read where status says so
    t_slot_st             r_status [QUEUE_DEPTH];
    logic [ID_W-1:0]      r_id     [QUEUE_DEPTH];
    logic [TIME_W-1:0]    r_rel    [QUEUE_DEPTH];
    logic [RETRY_W-1:0]   r_maxr   [QUEUE_DEPTH];
    logic [RETRY_W-1:0]   r_retry  [QUEUE_DEPTH];

    logic [UNIT_W-1:0]    r_unit;
    logic [TIME_W-1:0]    r_now;

    logic [FUNC_W-1:0]    r_func;
    logic [ID_W-1:0]      r_in_id;
    logic [TIME_W-1:0]    r_in_rel;
    logic [RETRY_W-1:0]   r_in_maxr;
    logic                 r_in_failed;

    logic [IDX_W-1:0]     r_scan;
    logic                 r_found;
    logic                 r_more;
    logic [IDX_W-1:0]     r_best_idx;
    logic [TIME_W-1:0]    r_best_age;
    logic [ID_W-1:0]      r_best_id;
    logic [TIME_W-1:0]    r_best_rel;
    logic [RETRY_W-1:0]   r_best_maxr;
    logic [RETRY_W-1:0]   r_best_retry;
    logic [CNT_W-1:0]     r_n;

    logic [KIND_W-1:0]    r_res_kind;
    logic [ID_W-1:0]      r_res_id;
    logic [RETRY_W-1:0]   r_res_retry;
    logic [TIME_W-1:0]    r_res_rel;
    logic                 r_res_last;
    logic                 r_out_valid;

    // walker
    t_slot_st             scan_st;
    logic [TIME_W-1:0]    scan_age;
    logic                 scan_due;
    logic                 scan_hit;

    always_comb begin
        scan_st  = r_status[r_scan];
        scan_age = r_now - r_rel[r_scan];
        scan_due = (scan_st == SLOT_SCHED) && !scan_age[TIME_W-1];
        case (r_func)
            FUNC_INSERT: scan_hit = (scan_st == SLOT_EMPTY) && !r_found;
            FUNC_REPORT: scan_hit = (scan_st == SLOT_RUN) && (r_id[r_scan] == r_in_id)
                                    && !r_found;
            FUNC_TICK:   scan_hit = scan_due && (!r_found || scan_age > r_best_age);
            default:     scan_hit = 1'b0;
        endcase
    end

    // decision on the chosen slot
    logic [TIME_W-1:0]    backoff;
    logic [TIME_W-1:0]    requeue_rel;
    logic [RETRY_W:0]     retry_inc;
    logic                 wr_st_en;
    t_slot_st             wr_st;
    logic                 wr_pay_en;
    logic [ID_W-1:0]      wr_id;
    logic [TIME_W-1:0]    wr_rel;
    logic [RETRY_W-1:0]   wr_maxr;
    logic [RETRY_W-1:0]   wr_retry;
    logic [KIND_W-1:0]    nx_kind;
    logic [ID_W-1:0]      nx_id;
    logic [RETRY_W-1:0]   nx_retry;
    logic [TIME_W-1:0]    nx_rel;
    logic                 nx_last;

    always_comb begin
        backoff     = {{(TIME_W-UNIT_W){1'b0}}, r_unit} << r_best_retry;
        requeue_rel = r_now + backoff;
        retry_inc   = {1'b0, r_best_retry} + 1'b1;

        wr_st_en  = 1'b0;
        wr_st     = SLOT_EMPTY;
        wr_pay_en = 1'b0;
        wr_id     = r_in_id;
        wr_rel    = r_in_rel;
        wr_maxr   = r_in_maxr;
        wr_retry  = '0;
        nx_kind   = KIND_UNKNOWN;
        nx_id     = r_in_id;
        nx_retry  = '0;
        nx_rel    = '0;
        nx_last   = 1'b1;

        case (r_func)
            FUNC_INSERT: begin
                nx_rel = r_in_rel;
                if (r_found) begin
                    wr_st_en  = 1'b1;
                    wr_st     = SLOT_SCHED;
                    wr_pay_en = 1'b1;
                    nx_kind   = KIND_INSERTED;
                end else begin
                    nx_kind   = KIND_FULL;
                end
            end
            FUNC_TICK: begin
                wr_st_en = 1'b1;
                wr_st    = SLOT_RUN;
                nx_kind  = KIND_DISPATCHED;
                nx_id    = r_best_id;
                nx_retry = r_best_retry;
                nx_rel   = r_best_rel;
                // the dispatch cap or no other due job ends the burst
                nx_last  = !r_more || (r_n == CNT_W'(MAX_RES-1));
            end
            FUNC_REPORT: begin
                if (r_found) begin
                    nx_retry = r_best_retry;
                    nx_rel   = r_best_rel;
                    wr_st_en = 1'b1;
                    if (!r_in_failed) begin
                        wr_st   = SLOT_EMPTY;
                        nx_kind = KIND_COMPLETED;
                    end else if (retry_inc <= {1'b0, r_best_maxr}) begin
                        wr_st     = SLOT_SCHED;
                        wr_pay_en = 1'b1;
                        wr_id     = r_best_id;
                        wr_rel    = requeue_rel;
                        wr_maxr   = r_best_maxr;
                        wr_retry  = retry_inc[RETRY_W-1:0];
                        nx_kind   = KIND_REQUEUED;
                        nx_retry  = retry_inc[RETRY_W-1:0];
                        nx_rel    = requeue_rel;
                    end else begin
                        wr_st   = SLOT_EMPTY;
                        nx_kind = KIND_FAILED;
                    end
                end
            end
            default: begin
                wr_st_en = 1'b0;
            end
        endcase
    end

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_status[i] <= SLOT_EMPTY;
            end
            r_unit      <= BACKOFF_RST;
            r_now       <= '0;
            r_func      <= FUNC_INSERT;
            r_scan      <= '0;
            r_found     <= 1'b0;
            r_more      <= 1'b0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_unit <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_func <= i_func;
                r_n    <= '0;
                if (i_func == FUNC_TICK) begin
                    r_now <= r_now + 1'b1;
                end
            end
            if (i_cmd.next_job) begin
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.scan_clr) begin
                r_scan  <= '0;
                r_found <= 1'b0;
                r_more  <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_scan <= r_scan + 1'b1;
                if (scan_hit) begin
                    r_found <= 1'b1;
                end
                if (scan_due && r_found) begin
                    r_more <= 1'b1;
                end
            end
            if (i_cmd.decide && wr_st_en) begin
                r_status[r_best_idx] <= wr_st;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_id     <= i_job_id;
            r_in_rel    <= i_release_time;
            r_in_maxr   <= i_max_retry;
            r_in_failed <= i_outcome_failed;
        end
        if (i_cmd.scan_step && scan_hit) begin
            r_best_idx   <= r_scan;
            r_best_age   <= scan_age;
            r_best_id    <= r_id[r_scan];
            r_best_rel   <= r_rel[r_scan];
            r_best_maxr  <= r_maxr[r_scan];
            r_best_retry <= r_retry[r_scan];
        end
        if (i_cmd.decide && wr_pay_en) begin
            r_id[r_best_idx]    <= wr_id;
            r_rel[r_best_idx]   <= wr_rel;
            r_maxr[r_best_idx]  <= wr_maxr;
            r_retry[r_best_idx] <= wr_retry;
        end
        if (i_cmd.decide) begin
            r_res_kind  <= nx_kind;
            r_res_id    <= nx_id;
            r_res_retry <= nx_retry;
            r_res_rel   <= nx_rel;
            r_res_last  <= nx_last;
        end
        if (i_cmd.out_load) begin
            o_m_kind    <= r_res_kind;
            o_m_job_id  <= r_res_id;
            o_m_retry   <= r_res_retry;
            o_m_release <= r_res_rel;
            o_m_last    <= r_res_last;
        end
    end

    assign o_m_valid       = r_out_valid;
    assign o_sts.func      = r_func;
    assign o_sts.scan_done = (r_scan == IDX_W'(QUEUE_DEPTH-1));
    assign o_sts.found     = r_found;
    assign o_sts.res_last  = r_res_last;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

endmodule

`default_nettype wire

[rtl/core/timed_job_queue_retry_backoff_top.sv]
// ----------------------------------------------------------------------------
// timed_job_queue_retry_backoff_top
// Table of timed jobs with dispatch on tick and exponential retry backoff.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// s        in   i_s_tvalid/o_s_tready  tuser func; tdata id, release, max_retry, failed
// m        out  o_m_tvalid/i_m_tready  tuser kind; tdata id, retries, release; tlast
// cfg      in   i_cfg_we               i_cfg_wdata = backoff unit in ticks
//
// Insert and report accept the beat, walk the table one slot per cycle, take a
// decision and load the result into the output register. A tick accepts the
// beat, then walks, decides and emits for each dispatched job in turn; with
// nothing due it ends after the walk and the decision.
// Reset clears every slot at once; no clearing pass. A stalled result beat
// holds the block before its next result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_job_queue_retry_backoff_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [tjq_pkg::UNIT_W-1:0]        i_cfg_wdata,
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    // [15:0] job_id, [47:16] release_time, [51:48] max_retry, [52] outcome_failed
    input  wire  [tjq_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // [1:0] func
    input  wire  [tjq_pkg::FUNC_W-1:0]        i_s_tuser,
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    // [15:0] job_id_res, [19:16] retry_count, [51:20] release_time_res
    output logic [tjq_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // [2:0] kind
    output logic [tjq_pkg::KIND_W-1:0]        o_m_tuser,
    output logic                              o_m_tlast
);
    import tjq_pkg::*;

    t_cmd                 cmd;
    t_sts                 sts;
    logic [ID_W-1:0]      m_id;
    logic [RETRY_W-1:0]   m_retry;
    logic [TIME_W-1:0]    m_rel;

    tjq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_func   (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tjq_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_func           (i_s_tuser),
        .i_job_id         (i_s_tdata[15:0]),
        .i_release_time   (i_s_tdata[47:16]),
        .i_max_retry      (i_s_tdata[51:48]),
        .i_outcome_failed (i_s_tdata[52]),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_m_tready       (i_m_tready),
        .o_m_valid        (o_m_tvalid),
        .o_m_kind         (o_m_tuser),
        .o_m_job_id       (m_id),
        .o_m_retry        (m_retry),
        .o_m_release      (m_rel),
        .o_m_last         (o_m_tlast)
    );

    assign o_m_tdata = {4'b0, m_rel, m_retry, m_id};

endmodule

`default_nettype wire

[rtl/core/tjq_chk.sv]
// ----------------------------------------------------------------------------
// tjq_chk
// Port-level checks of the timed job queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_job_queue_retry_backoff_top_defines.svh"

module tjq_chk (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_s_tvalid,
    input wire                            o_s_tready,
    input wire [tjq_pkg::FUNC_W-1:0]      i_s_tuser,
    input wire                            o_m_tvalid,
    input wire                            i_m_tready,
    input wire [tjq_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input wire [tjq_pkg::KIND_W-1:0]      o_m_tuser,
    input wire                            o_m_tlast
);
    import tjq_pkg::*;

    // a stalled result beat keeps its payload
    `TJQ_ASSERT_NEXT(a_m_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast),
        "result beat changed under stall")

    // an insert always produces a result, so the input side must close
    `TJQ_ASSERT_NEXT(a_ins_busy, i_clk, i_rst_n,
        i_s_tvalid && o_s_tready && i_s_tuser == FUNC_INSERT,
        !o_s_tready, "input still open after insert beat")

    // only dispatch bursts span several beats
    `TJQ_ASSERT_NOW(a_single_last, i_clk, i_rst_n,
        o_m_tvalid && o_m_tuser != KIND_DISPATCHED,
        o_m_tlast, "single-beat result without tlast")

    // unknown job answers carry no retries and no release tick
    `TJQ_ASSERT_NOW(a_unknown_zero, i_clk, i_rst_n,
        o_m_tvalid && o_m_tuser == KIND_UNKNOWN,
        o_m_tdata[51:16] == 36'd0, "unknown job result with nonzero fields")

endmodule

bind timed_job_queue_retry_backoff_top tjq_chk u_tjq_chk (.*);

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed job queue with retry backoff. Directed
// tests cover field extremes, wrap-around due tests, retry exhaustion and a
// full table. Random mixes of inserts, ticks and reports then run under
// several backoff units with random gaps on both streams. A job-table
// predictor in the bench computes every result beat; a monitor compares each
// accepted beat field by field against the oldest pending one.
// ----------------------------------------------------------------------------

module tb_top;
    import tjq_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 3 * (QUEUE_DEPTH + 3);

    typedef struct {
        t_slot_st           st;
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  rel;
        logic [RETRY_W-1:0] max_retry;
        logic [RETRY_W-1:0] retries;
    } job_slot_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    id;
        logic [RETRY_W-1:0] retries;
        logic [TIME_W-1:0]  rel;
        logic               last;
    } job_event_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [UNIT_W-1:0]     i_cfg_wdata = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata = '0;
    logic [FUNC_W-1:0]     i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic [KIND_W-1:0]     o_m_tuser;
    logic                  o_m_tlast;

    // bench copy of the job table
    job_slot_t          job_slots [QUEUE_DEPTH];
    logic [TIME_W-1:0]  tick_now;
    logic [UNIT_W-1:0]  backoff_unit;
    job_event_t         awaited_job_events [$];

    int error_count = 0;
    int hold_off_cycles = 0;
    bit steady_flow = 1'b0;

    timed_job_queue_retry_backoff_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (steady_flow || $urandom_range(0, 99) < 55) return 0;
        return idle_length();
    endfunction

    function automatic void log_event(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                      logic [RETRY_W-1:0] retries, logic [TIME_W-1:0] rel);
        job_event_t ev;
        ev.kind = kind;
        ev.id = id;
        ev.retries = retries;
        ev.rel = rel;
        ev.last = 1'b0;
        awaited_job_events.insert(awaited_job_events.size(), ev);
    endfunction

    task automatic predict_job_results(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id,
                                       input logic [TIME_W-1:0] rel,
                                       input logic [RETRY_W-1:0] maxr, input logic failed);
        int n_out;
        int best;
        int hit;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] best_age;
        logic [TIME_W-1:0] delay_ticks;
        job_event_t ev;
        n_out = 0;
        case (func)
            FUNC_INSERT: begin
                hit = -1;
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    if (hit < 0 && job_slots[i].st == SLOT_EMPTY) hit = i;
                if (hit < 0) begin
                    log_event(KIND_FULL, id, '0, rel);
                end else begin
                    job_slots[hit].st = SLOT_SCHED;
                    job_slots[hit].id = id;
                    job_slots[hit].rel = rel;
                    job_slots[hit].max_retry = maxr;
                    job_slots[hit].retries = '0;
                    log_event(KIND_INSERTED, id, '0, rel);
                end
                n_out = 1;
            end
            FUNC_TICK: begin
                tick_now = tick_now + 32'd1;
                while (n_out < MAX_RES) begin
                    best = -1;
                    best_age = '0;
                    for (int i = 0; i < QUEUE_DEPTH; i++) begin
                        if (job_slots[i].st != SLOT_SCHED) continue;
                        // negative signed distance means not yet due
                        age = tick_now - job_slots[i].rel;
                        if (age[TIME_W-1]) continue;
                        if (best < 0 || age > best_age) begin
                            best = i;
                            best_age = age;
                        end
                    end
                    if (best < 0) break;
                    job_slots[best].st = SLOT_RUN;
                    log_event(KIND_DISPATCHED, job_slots[best].id, job_slots[best].retries,
                              job_slots[best].rel);
                    n_out++;
                end
            end
            FUNC_REPORT: begin
                hit = -1;
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    if (hit < 0 && job_slots[i].st == SLOT_RUN && job_slots[i].id == id)
                        hit = i;
                if (hit < 0) begin
                    log_event(KIND_UNKNOWN, id, '0, '0);
                end else if (!failed) begin
                    job_slots[hit].st = SLOT_EMPTY;
                    log_event(KIND_COMPLETED, id, job_slots[hit].retries, job_slots[hit].rel);
                end else if (int'(job_slots[hit].retries) + 1 <= int'(job_slots[hit].max_retry)) begin
                    delay_ticks = 32'(backoff_unit) << job_slots[hit].retries;
                    job_slots[hit].retries = job_slots[hit].retries + 4'd1;
                    job_slots[hit].rel = tick_now + delay_ticks;
                    job_slots[hit].st = SLOT_SCHED;
                    log_event(KIND_REQUEUED, id, job_slots[hit].retries, job_slots[hit].rel);
                end else begin
                    job_slots[hit].st = SLOT_EMPTY;
                    log_event(KIND_FAILED, id, job_slots[hit].retries, job_slots[hit].rel);
                end
                n_out = 1;
            end
            default: ;
        endcase
        if (n_out > 0) begin
            ev = awaited_job_events.pop_back();
            ev.last = 1'b1;
            awaited_job_events.insert(awaited_job_events.size(), ev);
        end
    endtask

    task automatic send_beat(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] rel, input logic [RETRY_W-1:0] maxr,
                             input logic failed);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser <= func;
        i_s_tdata <= {3'b000, failed, maxr, rel, id};
        do @(posedge i_clk); while (!o_s_tready);
        predict_job_results(func, id, rel, maxr, failed);
        gap = sender_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // unused fields of each beat carry random junk
    task automatic send_insert(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] rel,
                               input logic [RETRY_W-1:0] maxr);
        send_beat(FUNC_INSERT, id, rel, maxr, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_tick();
        send_beat(FUNC_TICK, 16'($urandom), $urandom, 4'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_report(input logic [ID_W-1:0] id, input logic failed);
        send_beat(FUNC_REPORT, id, $urandom, 4'($urandom), failed);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (awaited_job_events.size() != 0) @(posedge i_clk);
        // a tick with nothing due can still be walking the table
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_backoff(input logic [UNIT_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        backoff_unit = value;
    endtask

    task automatic run_random_mix(input int n_items);
        int done_items;
        int pick;
        int slot;
        logic failed;
        logic [ID_W-1:0] id;
        logic [TIME_W-1:0] rel;
        int running [$];
        done_items = 0;
        while (done_items < n_items) begin
            running.delete();
            for (int i = 0; i < QUEUE_DEPTH; i++)
                if (job_slots[i].st == SLOT_RUN) running.insert(running.size(), i);
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_beat(FUNC_UNUSED, 16'($urandom), $urandom, 4'($urandom),
                          1'($urandom_range(0, 1)));
            end else begin
                done_items++;
                if (pick < 35) begin
                    if ($urandom_range(0, 3) == 0) id = 16'h00A0 + 16'($urandom_range(0, 3));
                    else id = 16'($urandom_range(0, 65535));
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: rel = tick_now + 32'($urandom_range(0, 8));
                        6, 7:             rel = tick_now - 32'($urandom_range(0, 8));
                        default:          rel = tick_now - 32'($urandom_range(0, 32'h7FFF_FF00));
                    endcase
                    send_insert(id, rel, 4'($urandom_range(0, 15)));
                end else if (pick < 62) begin
                    send_tick();
                end else if (pick < 92 && running.size() > 0) begin
                    slot = running[$urandom_range(0, running.size() - 1)];
                    failed = 1'($urandom_range(0, 1));
                    // long backoffs park a slot for the rest of the run; keep them rare
                    if (failed && job_slots[slot].retries < job_slots[slot].max_retry &&
                        (32'(backoff_unit) << job_slots[slot].retries) > 32'd64)
                        failed = ($urandom_range(0, 9) == 0);
                    send_report(job_slots[slot].id, failed);
                end else if (pick < 92) begin
                    send_tick();
                end else begin
                    send_report(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    // reset unit of 1000 seen through a requeue; reports that match no running job
    task automatic test_reset_backoff();
        send_insert(16'h0000, 32'd1, 4'hF);
        send_tick();
        send_report(16'h0000, 1'b1);
        send_report(16'hFFFF, 1'b0);
        send_report(16'h0000, 1'b0);
    endtask

    task automatic test_wrap_and_retry();
        send_insert(16'hFFFF, 32'hFFFF_FFFF, 4'h0);
        send_insert(16'h1234, tick_now + 32'd2, 4'h1);
        // exactly half the range behind after the next tick: reads as future
        send_insert(16'h8000, tick_now + 32'd1 - 32'h8000_0000, 4'h3);
        send_insert(16'h7FFF, tick_now + 32'd1 - 32'h7FFF_FFFF, 4'h2);
        send_tick();
        send_tick();
        send_report(16'hFFFF, 1'b1);
        send_report(16'h7FFF, 1'b0);
        send_report(16'h1234, 1'b1);
        send_tick();
        send_report(16'h1234, 1'b1);
        send_beat(FUNC_UNUSED, '1, '1, '1, 1'b1);
        send_tick();
    endtask

    task automatic test_table_full();
        for (int k = 0; k < QUEUE_DEPTH - 1; k++)
            send_insert(16'h00A0 + 16'(k % 3), tick_now - 32'(k), 4'($urandom_range(0, 15)));
        send_tick();
    endtask

    task automatic test_output_stall();
        hold_off_cycles = 400;
        run_random_mix(24);
    endtask

    task automatic test_backoff_sweep();
        logic [UNIT_W-1:0] units [4];
        units = '{16'd1, 16'hFFFF, 16'd2, 16'd3};
        for (int k = 0; k < 4; k++) begin
            wait_idle();
            write_backoff(units[k]);
            steady_flow = (k == 2);
            run_random_mix(80);
        end
        steady_flow = 1'b0;
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 3) == 0) stall_left = idle_length();
            end
        end
    end

    function automatic void check_field(string what, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        job_event_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (awaited_job_events.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got kind %0d id %0h",
                         $time, o_m_tuser, o_m_tdata[15:0]);
                error_count++;
            end else begin
                want = awaited_job_events.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_m_tuser));
                check_field("job_id", 32'(want.id), 32'(o_m_tdata[15:0]));
                check_field("retry_count", 32'(want.retries), 32'(o_m_tdata[19:16]));
                check_field("release_time", want.rel, o_m_tdata[51:20]);
                check_field("tdata pad", 32'd0, 32'(o_m_tdata[55:52]));
                check_field("tlast", 32'(want.last), 32'(o_m_tlast));
            end
        end
    end

    initial begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            job_slots[i].st = SLOT_EMPTY;
            job_slots[i].id = '0;
            job_slots[i].rel = '0;
            job_slots[i].max_retry = '0;
            job_slots[i].retries = '0;
        end
        tick_now = '0;
        backoff_unit = BACKOFF_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_backoff();
        wait_idle();
        write_backoff(16'd0);
        test_wrap_and_retry();
        test_table_full();
        test_output_stall();
        run_random_mix(60);
        test_backoff_sweep();

        wait_idle();
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
